/* rtl/hbfp_pkg.sv */
// Shared types and codes for the best-first picker.
package hbfp_pkg;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_PICK  = 2'd2;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_PREF = 2'd1;
  localparam logic [1:0] KIND_HEAP = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [31:0]        item;
    logic signed [31:0] score;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        picked_item;
    logic signed [31:0] picked_score;
    logic               found;
    logic               was_preferred;
  } out_item_t;

  typedef struct packed {
    logic [31:0]        item;
    logic signed [31:0] score;
  } entry_t;

  typedef struct packed {
    logic       start;
    logic       load;
    logic       bld_init;
    logic       bld_rd;
    logic       bld_load;
    logic       pop_rd;
    logic       pop_load;
    logic       sift_rd;
    logic       sift_step;
    logic       out_load;
    logic [1:0] out_kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic item_nonzero;
    logic count_zero;
    logic count_full;
    logic bidx_zero;
    logic sift_stop;
    logic top_is_pref;
    logic out_free;
  } dp_stat_t;

endpackage

/* rtl/hbfp_ctrl.sv */
// Controller state machine that sequences start, load, heap build, pop and sift-down.
module hbfp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_opcode,
  output logic                 in_stall,
  input  hbfp_pkg::dp_stat_t   stat,
  output hbfp_pkg::ctrl_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PICK     = 4'd1;
  localparam logic [3:0] S_BLD_RD   = 4'd2;
  localparam logic [3:0] S_BLD_LD   = 4'd3;
  localparam logic [3:0] S_POP_RD   = 4'd4;
  localparam logic [3:0] S_POP_LD   = 4'd5;
  localparam logic [3:0] S_SIFT_RD  = 4'd6;
  localparam logic [3:0] S_SIFT_CMP = 4'd7;
  localparam logic [3:0] S_OUT      = 4'd8;

  localparam logic [1:0] PH_DONE = 2'd0;
  localparam logic [1:0] PH_PREF = 2'd1;
  localparam logic [1:0] PH_MAIN = 2'd2;

  logic [3:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       ready_r, ready_nxt;
  logic [1:0] kind_r, kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_DONE;
      ready_r <= 1'b0;
      kind_r  <= hbfp_pkg::KIND_NONE;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      ready_r <= ready_nxt;
      kind_r  <= kind_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    ready_nxt    = ready_r;
    kind_nxt     = kind_r;
    cmd          = '0;
    cmd.out_kind = kind_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_opcode)
            hbfp_pkg::OP_START: begin
              cmd.start = 1'b1;
              phase_nxt = stat.item_nonzero ? PH_PREF : PH_MAIN;
              ready_nxt = 1'b0;
            end
            hbfp_pkg::OP_LOAD: begin
              cmd.load = 1'b1;
              if (!stat.count_full) begin
                ready_nxt = 1'b0;
              end
            end
            hbfp_pkg::OP_PICK: begin
              case (phase_r)
                PH_PREF: begin
                  phase_nxt = PH_MAIN;
                  kind_nxt  = hbfp_pkg::KIND_PREF;
                  state_nxt = S_OUT;
                end
                PH_MAIN: begin
                  state_nxt = S_PICK;
                end
                default: begin
                  kind_nxt  = hbfp_pkg::KIND_NONE;
                  state_nxt = S_OUT;
                end
              endcase
            end
            default: begin
            end
          endcase
        end
      end
      S_PICK: begin
        if (stat.count_zero) begin
          phase_nxt = PH_DONE;
          kind_nxt  = hbfp_pkg::KIND_NONE;
          state_nxt = S_OUT;
        end else if (!ready_r) begin
          cmd.bld_init = 1'b1;
          state_nxt    = S_BLD_RD;
        end else begin
          state_nxt = S_POP_RD;
        end
      end
      S_BLD_RD: begin
        if (stat.bidx_zero) begin
          ready_nxt = 1'b1;
          state_nxt = S_POP_RD;
        end else begin
          cmd.bld_rd = 1'b1;
          state_nxt  = S_BLD_LD;
        end
      end
      S_BLD_LD: begin
        cmd.bld_load = 1'b1;
        state_nxt    = S_SIFT_RD;
      end
      S_POP_RD: begin
        cmd.pop_rd = 1'b1;
        state_nxt  = S_POP_LD;
      end
      S_POP_LD: begin
        cmd.pop_load = 1'b1;
        state_nxt    = S_SIFT_RD;
      end
      S_SIFT_RD: begin
        cmd.sift_rd = 1'b1;
        state_nxt   = S_SIFT_CMP;
      end
      S_SIFT_CMP: begin
        cmd.sift_step = 1'b1;
        if (!stat.sift_stop) begin
          state_nxt = S_SIFT_RD;
        end else if (!ready_r) begin
          state_nxt = S_BLD_RD;
        end else if (stat.top_is_pref) begin
          state_nxt = S_PICK;
        end else begin
          kind_nxt  = hbfp_pkg::KIND_HEAP;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/hbfp_dp.sv */
// Datapath with the heap memory, sift-down compare, counters and the result register.
module hbfp_dp #(
  parameter int CAPACITY = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hbfp_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output hbfp_pkg::out_item_t  out_data,
  input  hbfp_pkg::ctrl_cmd_t  cmd,
  output hbfp_pkg::dp_stat_t   stat
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;

  hbfp_pkg::entry_t mem [CAPACITY];

  logic [CW-1:0]       count_r;
  logic [CW-1:0]       bidx_r;
  logic [AW-1:0]       node_r;
  logic [31:0]         pref_r;
  hbfp_pkg::entry_t    cur_r;
  hbfp_pkg::entry_t    top_r;
  hbfp_pkg::entry_t    rd_a_r;
  hbfp_pkg::entry_t    rd_b_r;
  logic                out_valid_r;
  hbfp_pkg::out_item_t out_data_r;
  hbfp_pkg::out_item_t out_data_nxt;

  logic [XW-1:0]       l_w;
  logic [XW-1:0]       r_w;
  logic [XW-1:0]       cnt_x;
  logic                l_ok;
  logic                r_ok;
  logic                l_gt;
  logic                r_gt;
  logic signed [31:0]  best_score;
  logic [CW-1:0]       bidx_m1;
  logic [CW-1:0]       count_m1;
  logic [AW-1:0]       raddr_a;
  logic [AW-1:0]       raddr_b;
  logic                we;
  logic [AW-1:0]       waddr;
  hbfp_pkg::entry_t    wdata;
  logic                count_full;

  assign l_w        = {1'b0, node_r, 1'b1};
  assign r_w        = l_w + XW'(1);
  assign cnt_x      = XW'(count_r);
  assign l_ok       = (l_w < cnt_x);
  assign r_ok       = (r_w < cnt_x);
  assign l_gt       = l_ok && (rd_a_r.score > cur_r.score);
  assign best_score = l_gt ? rd_a_r.score : cur_r.score;
  assign r_gt       = r_ok && (rd_b_r.score > best_score);
  assign bidx_m1    = bidx_r - CW'(1);
  assign count_m1   = count_r - CW'(1);
  assign count_full = (count_r >= CW'(CAPACITY));

  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    if (cmd.bld_rd) begin
      raddr_a = bidx_m1[AW-1:0];
    end else if (cmd.pop_rd) begin
      raddr_b = count_m1[AW-1:0];
    end else if (cmd.sift_rd) begin
      if (l_w < XW'(CAPACITY)) begin
        raddr_a = l_w[AW-1:0];
      end
      if (r_w < XW'(CAPACITY)) begin
        raddr_b = r_w[AW-1:0];
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = node_r;
    wdata = cur_r;
    if (cmd.load) begin
      we          = !count_full;
      waddr       = count_r[AW-1:0];
      wdata.item  = in_data.item;
      wdata.score = in_data.score;
    end else if (cmd.sift_step) begin
      we = 1'b1;
      if (r_gt) begin
        wdata = rd_b_r;
      end else if (l_gt) begin
        wdata = rd_a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= mem[raddr_a];
    rd_b_r <= mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pref_r  <= '0;
    end else begin
      if (cmd.start) begin
        count_r <= '0;
        pref_r  <= in_data.item;
      end else if (cmd.load && !count_full) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.pop_load) begin
        count_r <= count_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bld_init) begin
      bidx_r <= count_r >> 1;
    end else if (cmd.bld_rd) begin
      bidx_r <= bidx_m1;
    end
    if (cmd.bld_load) begin
      cur_r  <= rd_a_r;
      node_r <= bidx_r[AW-1:0];
    end else if (cmd.pop_load) begin
      top_r  <= rd_a_r;
      cur_r  <= rd_b_r;
      node_r <= '0;
    end else if (cmd.sift_step) begin
      if (r_gt) begin
        node_r <= r_w[AW-1:0];
      end else if (l_gt) begin
        node_r <= l_w[AW-1:0];
      end
    end
  end

  always_comb begin
    out_data_nxt = '0;
    case (cmd.out_kind)
      hbfp_pkg::KIND_PREF: begin
        out_data_nxt.picked_item   = pref_r;
        out_data_nxt.found         = 1'b1;
        out_data_nxt.was_preferred = 1'b1;
      end
      hbfp_pkg::KIND_HEAP: begin
        out_data_nxt.picked_item  = top_r.item;
        out_data_nxt.picked_score = top_r.score;
        out_data_nxt.found        = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign stat.item_nonzero = (in_data.item != 32'd0);
  assign stat.count_zero   = (count_r == '0);
  assign stat.count_full   = count_full;
  assign stat.bidx_zero    = (bidx_r == '0);
  assign stat.sift_stop    = !l_gt && !r_gt;
  assign stat.top_is_pref  = (top_r.item == pref_r);
  assign stat.out_free     = !out_valid_r || !out_stall;

endmodule

/* rtl/heap_best_first_picker.sv */
// Top level of the best-first picker: controller, heap datapath and checks.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+---------------------------------------
//   in_     | in  | in_valid / in_stall    | opcode, item, score
//   out_    | out | out_valid / out_stall  | picked_item, picked_score, found, was_preferred
//
// Start and load are taken in the idle state; a pick in the preferred or done phase goes
// straight to the output state. A heap pick moves the last entry to the root and sifts it
// down, each level a read of both children from the memory and then a compare/write.
// The first pick after loads also builds the heap, one sift-down per inner node.
// Synchronous active-low reset empties the list; memory contents are not cleared.
// A finished result waits in the output register while start and load items are taken.
module heap_best_first_picker #(
  parameter int CAPACITY = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  hbfp_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output hbfp_pkg::out_item_t  out_data
);

  hbfp_pkg::ctrl_cmd_t cmd;
  hbfp_pkg::dp_stat_t  stat;

  hbfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  hbfp_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  a_pref_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.was_preferred |-> out_data.found)
    else $error("preferred result without found");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |->
      (out_data.picked_item == 32'd0) && (out_data.picked_score == 32'sd0))
    else $error("not-found result carries data");

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.sift_step))
    else $error("two memory writers in one cycle");

  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded over a pending result");

endmodule
